[rtl/dwwd_pkg.sv]
// Shared types and constants for the double-word by word divider.
// Used by dwwd_ctrl, dwwd_dp and double_word_by_word_divide_top; depends on nothing.
package dwwd_pkg;

  // Default machine word width.
  localparam int WORD_BITS_DEF = 32;

  // Controller states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } dwwd_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture a new transaction
    logic step;      // one restoring division step
    logic load_out;  // move the result into the output register
  } dwwd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic err;       // zero divisor or quotient overflow
  } dwwd_status_t;

endpackage

[rtl/double_word_by_word_divide_top.sv]
// Unsigned double-word by word divider, top level. From acceptance to a loaded
// result a transaction passes through the capture of the operands, one
// restoring step per quotient bit through the single shared compare-and-subtract
// unit, and the move into the output register. A zero divisor or a high word
// not below the divisor skips the steps and gives an error result (quotient
// zero, remainder all ones).
// The output register lets a new transaction start while a result is waiting.
// Depends on dwwd_pkg, dwwd_ctrl and dwwd_dp.
module double_word_by_word_divide_top import dwwd_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [WORD_BITS-1:0] in_dividend_high,
  input  logic [WORD_BITS-1:0] in_dividend_low,
  input  logic [WORD_BITS-1:0] in_divisor,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [WORD_BITS-1:0] out_quotient,
  output logic [WORD_BITS-1:0] out_remainder,
  output logic                 out_div_error
);

  dwwd_cmd_t    cmd;
  dwwd_status_t status;

  // Sequencing and handshakes.
  dwwd_ctrl #(
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic and result storage.
  dwwd_dp #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk              (clk),
    .in_dividend_high (in_dividend_high),
    .in_dividend_low  (in_dividend_low),
    .in_divisor       (in_divisor),
    .cmd              (cmd),
    .status           (status),
    .out_quotient     (out_quotient),
    .out_remainder    (out_remainder),
    .out_div_error    (out_div_error)
  );

  // Only one transaction is in the datapath at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a transaction is in progress");

  // An error result always carries the fixed quotient and remainder.
  a_error_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_error |-> out_quotient == '0 && out_remainder == '1)
    else $error("error result with wrong quotient or remainder");

  // The result register is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

[rtl/dwwd_dp.sv]
// Datapath of the divider: partial remainder, dividend/quotient shift register,
// one shared compare-and-subtract unit and the output register. Depends on dwwd_pkg.
module dwwd_dp import dwwd_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic [WORD_BITS-1:0] in_dividend_high,
  input  logic [WORD_BITS-1:0] in_dividend_low,
  input  logic [WORD_BITS-1:0] in_divisor,
  input  dwwd_cmd_t            cmd,
  output dwwd_status_t         status,
  output logic [WORD_BITS-1:0] out_quotient,
  output logic [WORD_BITS-1:0] out_remainder,
  output logic                 out_div_error
);

  logic [WORD_BITS-1:0] rem_r, rem_nxt;
  logic [WORD_BITS-1:0] lo_r, lo_nxt;
  logic [WORD_BITS-1:0] div_r, div_nxt;
  logic                 err_r, err_nxt;
  logic [WORD_BITS-1:0] quo_out_r, quo_out_nxt;
  logic [WORD_BITS-1:0] rem_out_r, rem_out_nxt;
  logic                 err_out_r, err_out_nxt;

  logic [WORD_BITS:0]   shifted;
  logic                 ge;

  // One step: shift the next dividend bit into the remainder and subtract
  // the divisor when the shifted value (with its carry) is not below it.
  assign shifted = {rem_r, lo_r[WORD_BITS-1]};
  assign ge      = (shifted >= {1'b0, div_r});

  always_comb begin
    rem_nxt     = rem_r;
    lo_nxt      = lo_r;
    div_nxt     = div_r;
    err_nxt     = err_r;
    quo_out_nxt = quo_out_r;
    rem_out_nxt = rem_out_r;
    err_out_nxt = err_out_r;
    if (cmd.load) begin
      rem_nxt = in_dividend_high;
      lo_nxt  = in_dividend_low;
      div_nxt = in_divisor;
      err_nxt = (in_divisor == '0) || (in_dividend_high >= in_divisor);
    end else if (cmd.step) begin
      // The low word shifts out at the top while quotient bits fill the bottom.
      rem_nxt = ge ? (shifted[WORD_BITS-1:0] - div_r) : shifted[WORD_BITS-1:0];
      lo_nxt  = {lo_r[WORD_BITS-2:0], ge};
    end
    if (cmd.load_out) begin
      quo_out_nxt = err_r ? '0 : lo_r;
      rem_out_nxt = err_r ? '1 : rem_r;
      err_out_nxt = err_r;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    lo_r      <= lo_nxt;
    div_r     <= div_nxt;
    err_r     <= err_nxt;
    quo_out_r <= quo_out_nxt;
    rem_out_r <= rem_out_nxt;
    err_out_r <= err_out_nxt;
  end

  assign status.err    = err_r;
  assign out_quotient  = quo_out_r;
  assign out_remainder = rem_out_r;
  assign out_div_error = err_out_r;

endmodule

[rtl/dwwd_ctrl.sv]
// Controller of the divider: handshakes, step counter and sequencing of the datapath.
// Depends on dwwd_pkg.
module dwwd_ctrl import dwwd_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  dwwd_status_t status,
  output dwwd_cmd_t    cmd
);

  localparam int CNT_W = $clog2(WORD_BITS);

  dwwd_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Next-state logic: load, then one step per quotient bit (none on an error),
  // then hand the result to the output register once it is free.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = CNT_W'(WORD_BITS - 1);
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        // An error needs no steps; its result is fixed.
        if (status.err) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.step = 1'b1;
          cnt_nxt  = cnt_r - CNT_W'(1);
          if (cnt_r == '0) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[tb/tb_double_word_by_word_divide_top.sv]
// Self-checking testbench for the double-word by word divider.
// Depends on dwwd_pkg and double_word_by_word_divide_top; a scoreboard class predicts
// each quotient and remainder and checks results in the order of acceptance.
module tb_double_word_by_word_divide_top import dwwd_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = WORD_BITS_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 600;
  localparam logic [W-1:0] ONES = '1;
  localparam logic [W-1:0] TOP = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic [W-1:0] quotient;
    logic [W-1:0] remainder;
    logic         div_error;
  } div_result_t;

  // Holds the expected results of accepted transactions and checks the outputs.
  class quotient_checker;
    div_result_t pending_results[$];
    int          mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    // Restoring division, one quotient bit per step, most significant first.
    function div_result_t predict_division(logic [W-1:0] hi, logic [W-1:0] lo,
                                           logic [W-1:0] d);
      div_result_t res;
      logic [W-1:0] part;
      logic         carry;
      res.quotient  = '0;
      res.remainder = ONES;
      res.div_error = 1'b1;
      if (d == '0 || hi >= d) return res;
      part = hi;
      for (int i = W - 1; i >= 0; i--) begin
        carry = part[W-1];
        part  = {part[W-2:0], lo[i]};
        if (carry || part >= d) begin
          part = part - d;
          res.quotient[i] = 1'b1;
        end
      end
      res.remainder = part;
      res.div_error = 1'b0;
      return res;
    endfunction

    task report_mismatch(string msg);
      mismatch_count++;
      $display("%0t ns: mismatch: %s", $realtime, msg);
    endtask

    function void note_input(logic [W-1:0] hi, logic [W-1:0] lo, logic [W-1:0] d);
      pending_results.push_back(predict_division(hi, lo, d));
    endfunction

    task check_result(logic [W-1:0] q, logic [W-1:0] r, logic err);
      div_result_t exp_res;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result q=%h r=%h err=%b", q, r, err));
        return;
      end
      exp_res = pending_results.pop_front();
      if (q !== exp_res.quotient)
        report_mismatch($sformatf("quotient %h, expected %h", q, exp_res.quotient));
      if (r !== exp_res.remainder)
        report_mismatch($sformatf("remainder %h, expected %h", r, exp_res.remainder));
      if (err !== exp_res.div_error)
        report_mismatch($sformatf("div_error %b, expected %b", err, exp_res.div_error));
    endtask

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_valid;
  logic         in_ready;
  logic [W-1:0] in_dividend_high;
  logic [W-1:0] in_dividend_low;
  logic [W-1:0] in_divisor;
  logic         out_valid;
  logic         out_ready;
  logic [W-1:0] out_quotient;
  logic [W-1:0] out_remainder;
  logic         out_div_error;

  quotient_checker checker_h;
  bit              idle_en;
  int              quiet_cycles = 0;

  double_word_by_word_divide_top #(.WORD_BITS(W)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_dividend_high (in_dividend_high),
    .in_dividend_low  (in_dividend_low),
    .in_divisor       (in_divisor),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_quotient     (out_quotient),
    .out_remainder    (out_remainder),
    .out_div_error    (out_div_error)
  );

  // Clock with a 20 ns period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Sample both channels at the rising edge.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (out_valid && out_ready)
        checker_h.check_result(out_quotient, out_remainder, out_div_error);
      if (in_valid && in_ready)
        checker_h.note_input(in_dividend_high, in_dividend_low, in_divisor);
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Result side: ready with random stall bursts while idling is enabled.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (idle_en && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 13);
      end
    end
  end

  // Presents one transaction at the falling edge and holds it until accepted.
  task automatic send_item(logic [W-1:0] hi, logic [W-1:0] lo, logic [W-1:0] d);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_dividend_high <= hi;
    in_dividend_low  <= lo;
    in_divisor       <= d;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Random operands: mostly valid divisions of varied shape, some errors, some noise.
  task automatic make_item(output logic [W-1:0] hi, output logic [W-1:0] lo,
                           output logic [W-1:0] d);
    int kind;
    kind = $urandom_range(0, 99);
    lo = $urandom;
    if (kind < 70) begin
      case ($urandom_range(0, 4))
        0: d = $urandom;
        1: d = $urandom_range(1, 255);
        2: d = TOP | $urandom;
        3: d = TOP >> $urandom_range(0, W - 1);
        default: d = ONES - $urandom_range(0, 3);
      endcase
      if (d == '0) d = 1;
      case ($urandom_range(0, 9))
        0: hi = '0;
        1: hi = d - 1;
        default: hi = $urandom_range(d - 1, 0);
      endcase
      case ($urandom_range(0, 9))
        0: lo = '0;
        1: lo = ONES;
        default: lo = $urandom;
      endcase
    end else if (kind < 85) begin
      if ($urandom_range(0, 2) == 0) begin
        d  = '0;
        hi = $urandom;
      end else begin
        d  = $urandom;
        hi = $urandom_range(ONES, d);
      end
    end else begin
      hi = $urandom;
      d  = $urandom;
    end
  endtask

  initial begin
    logic [W-1:0] hi, lo, d;
    checker_h        = new();
    idle_en          = 1'b1;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_dividend_high = '0;
    in_dividend_low  = '0;
    in_divisor       = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: zero divisor, overflow at and above the divisor, extreme operands.
    send_item('0, '0, '0);
    send_item(ONES, ONES, '0);
    send_item(5, 7, 5);
    send_item(ONES, '0, ONES);
    send_item(6, '0, 5);
    send_item(TOP, 1, TOP);
    send_item('0, '0, 1);
    send_item('0, ONES, 1);
    send_item('0, ONES, ONES);
    send_item(ONES - 1, ONES, ONES);
    send_item(ONES - 1, '0, ONES);
    send_item('0, '0, ONES);
    send_item(TOP - 1, ONES, TOP);
    send_item('0, ONES, TOP);
    send_item(1, '0, 2);
    send_item('0, 100, 7);
    send_item('0, 42, 3);
    send_item('0, 5, 10);
    send_item('0, TOP, 1);
    send_item(32'h1234_5677, 32'h89AB_CDEF, 32'h1234_5678);
    send_item(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAB);

    // Random part: idling, a stretch without it, idling again, then none at the end.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 250) idle_en = 1'b0;
      else if (n == 400) idle_en = 1'b1;
      else if (n == 550) idle_en = 1'b0;
      make_item(hi, lo, d);
      send_item(hi, lo, d);
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then allow for late extras.
    while (checker_h.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (checker_h.mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
